FILE: rtl/core/ocep_pkg.sv
// Shared types, constants and the arctangent table for the orbit camera eye position block.
`timescale 1ns / 1ps

package ocep_pkg;

  // Field and datapath widths.
  localparam int unsigned OpW      = 2;
  localparam int unsigned DeltaW   = 16;
  localparam int unsigned AzW      = 15;
  localparam int unsigned PolW     = 14;
  localparam int unsigned RadW     = 23;
  localparam int unsigned CtrW     = 24;
  localparam int unsigned EyeW     = 25;
  localparam int unsigned AngW     = 14;
  localparam int unsigned CordW    = 27;
  localparam int unsigned AtanIdxW = 5;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 24;

  // Angle constants in Q4.12 radians.
  localparam logic signed [AzW:0] TwoPiQ12  = 16'sd25736;
  localparam logic signed [AzW:0] PiQ12     = 16'sd12868;
  localparam logic signed [AzW:0] HalfPiQ12 = 16'sd6434;
  localparam logic signed [AzW:0] FoldHiQ12 = 16'sd19302;
  localparam logic signed [AzW:0] PolarCap  = 16'sd6429;

  // Distance and output limits.
  localparam logic [RadW-1:0]        RadiusMax   = 23'h7FFFFF;
  localparam logic signed [EyeW-1:0] EyeMax      = 25'sh0FFFFFF;
  localparam logic signed [EyeW-1:0] EyeMin      = -25'sh1000000;
  localparam logic signed [CordW-1:0] CordicGain = 27'sd10188014;

  // Operation codes carried with each input transaction.
  typedef enum logic [OpW-1:0] {
    OP_ROT_AZ   = 2'd0,
    OP_ROT_POL  = 2'd1,
    OP_ZOOM     = 2'd2,
    OP_RESTART  = 2'd3
  } ocep_op_e;

  // Configuration register indexes.
  typedef enum logic [CfgAddrW-1:0] {
    CFG_CENTER_X      = 3'd0,
    CFG_CENTER_Y      = 3'd1,
    CFG_CENTER_Z      = 3'd2,
    CFG_MIN_RADIUS    = 3'd3,
    CFG_START_RADIUS  = 3'd4,
    CFG_START_AZIMUTH = 3'd5,
    CFG_START_POLAR   = 3'd6
  } ocep_cfg_idx_e;

  typedef struct packed {
    logic signed [CtrW-1:0] center_x;
    logic signed [CtrW-1:0] center_y;
    logic signed [CtrW-1:0] center_z;
    logic [RadW-1:0]        min_radius;
    logic [RadW-1:0]        start_radius;
    logic [AzW-1:0]         start_azimuth;
    logic signed [PolW-1:0] start_polar;
  } ocep_cfg_t;

  // Request from the sequencer to the pose state unit.
  typedef struct packed {
    logic                     start;
    ocep_op_e                 opcode;
    logic signed [DeltaW-1:0] delta;
  } ocep_pose_req_t;

  // Current pose and a one-cycle completion strobe.
  typedef struct packed {
    logic                   done;
    logic [AzW-1:0]         azimuth;
    logic signed [PolW-1:0] polar;
    logic [RadW-1:0]        radius;
  } ocep_pose_t;

  typedef struct packed {
    logic                   start;
    logic signed [AngW-1:0] angle;
  } ocep_cordic_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [CordW-1:0] cos_val;
    logic signed [CordW-1:0] sin_val;
  } ocep_cordic_rsp_t;

  // Arctangent of 2^-i in Q24 radians.
  function automatic logic signed [CordW-1:0] atan_q24(input logic [AtanIdxW-1:0] idx);
    logic signed [CordW-1:0] val;
    case (idx)
      5'd0:    val = 27'sd13176795;
      5'd1:    val = 27'sd7778716;
      5'd2:    val = 27'sd4110060;
      5'd3:    val = 27'sd2086331;
      5'd4:    val = 27'sd1047214;
      5'd5:    val = 27'sd524117;
      5'd6:    val = 27'sd262123;
      5'd7:    val = 27'sd131069;
      5'd8:    val = 27'sd65536;
      5'd9:    val = 27'sd32768;
      5'd10:   val = 27'sd16384;
      5'd11:   val = 27'sd8192;
      5'd12:   val = 27'sd4096;
      5'd13:   val = 27'sd2048;
      5'd14:   val = 27'sd1024;
      5'd15:   val = 27'sd512;
      5'd16:   val = 27'sd256;
      5'd17:   val = 27'sd128;
      5'd18:   val = 27'sd64;
      5'd19:   val = 27'sd32;
      default: val = 27'sd0;
    endcase
    return val;
  endfunction

endpackage

FILE: rtl/core/orbit_camera_eye_position.sv
// Top level: configuration registers, sequencer, shared multiplier and output register.
// A result takes two passes through the shared iterative CORDIC and four shared multiplies.
// A new item is taken only while the sequencer is idle, after the last result is computed;
//   an untaken result holds the next item before eye_x.
// The azimuth wrap adds or removes one turn per pass until the azimuth lies in [0, 2pi).
// Reset (asynchronous, active low) loads the register and pose reset values; no clearing pass.
`timescale 1ns / 1ps

module orbit_camera_eye_position #(
  parameter int unsigned CORDIC_STEPS = 14
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write port.
  input  logic                          cfg_we_i,
  input  logic [ocep_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [ocep_pkg::CfgDataW-1:0] cfg_wdata_i,
  // Input stream.
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [15:0]                   s_axis_tdata_i,  // [15:0] delta
  input  logic [1:0]                    s_axis_tuser_i,  // [1:0] opcode
  // Output stream.
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [79:0]                   m_axis_tdata_o   // [24:0] eye_x, [49:25] eye_y,
                                                         // [74:50] eye_z, [79:75] zero
);

  localparam int unsigned CordW = ocep_pkg::CordW;
  localparam int unsigned AngW  = ocep_pkg::AngW;
  localparam int unsigned AzW   = ocep_pkg::AzW;
  localparam int unsigned RadW  = ocep_pkg::RadW;
  localparam int unsigned EyeW  = ocep_pkg::EyeW;
  localparam int unsigned ProdW = 2 * CordW;
  localparam int unsigned Frac  = 24;
  localparam int unsigned RndW  = ProdW - Frac;
  localparam int unsigned SumW  = RndW + 1;
  localparam int unsigned PadW  = 80 - 3 * EyeW;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_POSE,
    ST_AZ,
    ST_POL,
    ST_MUL_RC,
    ST_RC,
    ST_MUL_X,
    ST_EYE_X,
    ST_MUL_Y,
    ST_EYE_Y,
    ST_MUL_Z,
    ST_EYE_Z
  } state_e;

  ocep_pkg::ocep_cfg_t        cfg_q;
  ocep_pkg::ocep_pose_req_t   pose_req;
  ocep_pkg::ocep_pose_t       pose;
  ocep_pkg::ocep_cordic_req_t cor_req;
  ocep_pkg::ocep_cordic_rsp_t cor_rsp;

  state_e                  state_q;
  logic                    pose_start_q;
  logic [1:0]              op_q;
  logic signed [15:0]      delta_q;
  logic                    cor_start_q;
  logic signed [AngW-1:0]  cor_angle_q;
  logic                    neg_q;
  logic                    out_valid_q;
  logic signed [CordW-1:0] ca_q, sa_q, cp_q, sp_q, rc_q;
  logic signed [ProdW-1:0] prod_q;
  logic signed [EyeW-1:0]  ex_q, ey_q, ez_q;

  logic                    in_txn;
  logic signed [AzW:0]     az_s;
  logic signed [AngW-1:0]  az_angle;
  logic                    az_neg;
  logic signed [CordW-1:0] mul_a, mul_b, rad_ext;
  logic signed [ProdW-1:0] prod_d;
  logic signed [RndW-1:0]  prod_rnd;
  logic signed [EyeW-1:0]  eye_sat;
  logic signed [ocep_pkg::CtrW-1:0] center_sel;

  assign in_txn = s_axis_tvalid_i && s_axis_tready_o;

  // Configuration registers; unlisted indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.center_x      <= '0;
      cfg_q.center_y      <= '0;
      cfg_q.center_z      <= '0;
      cfg_q.min_radius    <= 23'd256;
      cfg_q.start_radius  <= 23'd2560;
      cfg_q.start_azimuth <= '0;
      cfg_q.start_polar   <= '0;
    end else if (cfg_we_i) begin
      case (ocep_pkg::ocep_cfg_idx_e'(cfg_addr_i))
        ocep_pkg::CFG_CENTER_X:      cfg_q.center_x      <= cfg_wdata_i;
        ocep_pkg::CFG_CENTER_Y:      cfg_q.center_y      <= cfg_wdata_i;
        ocep_pkg::CFG_CENTER_Z:      cfg_q.center_z      <= cfg_wdata_i;
        ocep_pkg::CFG_MIN_RADIUS:    cfg_q.min_radius    <= cfg_wdata_i[RadW-1:0];
        ocep_pkg::CFG_START_RADIUS:  cfg_q.start_radius  <= cfg_wdata_i[RadW-1:0];
        ocep_pkg::CFG_START_AZIMUTH: cfg_q.start_azimuth <= cfg_wdata_i[AzW-1:0];
        ocep_pkg::CFG_START_POLAR:   cfg_q.start_polar   <= cfg_wdata_i[ocep_pkg::PolW-1:0];
        default: ;
      endcase
    end
  end

  // Pose state unit.
  assign pose_req.start  = pose_start_q;
  assign pose_req.opcode = ocep_pkg::ocep_op_e'(op_q);
  assign pose_req.delta  = delta_q;

  ocep_pose u_pose (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (pose_req),
    .cfg_i  (cfg_q),
    .pose_o (pose)
  );

  // Shared CORDIC, used for the azimuth and then the polar angle.
  assign cor_req.start = cor_start_q;
  assign cor_req.angle = cor_angle_q;

  ocep_cordic #(
    .Steps (CORDIC_STEPS)
  ) u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (cor_req),
    .rsp_o  (cor_rsp)
  );

  // Fold the azimuth into [-pi/2, pi/2]; the middle half-turn negates sine and cosine.
  assign az_s = $signed({1'b0, pose.azimuth});

  always_comb begin
    if (az_s <= ocep_pkg::HalfPiQ12) begin
      az_angle = AngW'(az_s);
      az_neg   = 1'b0;
    end else if (az_s < ocep_pkg::FoldHiQ12) begin
      az_angle = AngW'(az_s - ocep_pkg::PiQ12);
      az_neg   = 1'b1;
    end else begin
      az_angle = AngW'(az_s - ocep_pkg::TwoPiQ12);
      az_neg   = 1'b0;
    end
  end

  // Shared multiplier with operand selection by sequencer state.
  assign rad_ext = $signed({{(CordW - RadW){1'b0}}, pose.radius});

  always_comb begin
    case (state_q)
      ST_MUL_RC: begin
        mul_a = rad_ext;
        mul_b = cp_q;
      end
      ST_MUL_X: begin
        mul_a = rc_q;
        mul_b = ca_q;
      end
      ST_MUL_Y: begin
        mul_a = rad_ext;
        mul_b = sp_q;
      end
      default: begin
        mul_a = rc_q;
        mul_b = sa_q;
      end
    endcase
  end

  assign prod_d = mul_a * mul_b;

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  // Round half up to Q8, add the center and saturate.
  always_comb begin
    logic signed [ProdW-1:0] biased;
    logic signed [SumW-1:0]  sum;
    biased   = prod_q + (ProdW'(1) <<< (Frac - 1));
    prod_rnd = $signed(biased[ProdW-1:Frac]);
    case (state_q)
      ST_EYE_X: center_sel = cfg_q.center_x;
      ST_EYE_Y: center_sel = cfg_q.center_y;
      default:  center_sel = cfg_q.center_z;
    endcase
    sum = SumW'(center_sel) + SumW'(prod_rnd);
    if (sum > SumW'(ocep_pkg::EyeMax)) begin
      eye_sat = ocep_pkg::EyeMax;
    end else if (sum < SumW'(ocep_pkg::EyeMin)) begin
      eye_sat = ocep_pkg::EyeMin;
    end else begin
      eye_sat = EyeW'(sum);
    end
  end

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      pose_start_q <= 1'b0;
      cor_start_q  <= 1'b0;
      out_valid_q  <= 1'b0;
      op_q         <= '0;
      delta_q      <= '0;
      cor_angle_q  <= '0;
      neg_q        <= 1'b0;
    end else begin
      pose_start_q <= 1'b0;
      cor_start_q  <= 1'b0;
      // The receiver takes the pending result.
      if (out_valid_q && m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_txn) begin
            op_q         <= s_axis_tuser_i;
            delta_q      <= $signed(s_axis_tdata_i);
            pose_start_q <= 1'b1;
            state_q      <= ST_POSE;
          end
        end
        ST_POSE: begin
          if (pose.done) begin
            cor_angle_q <= az_angle;
            neg_q       <= az_neg;
            cor_start_q <= 1'b1;
            state_q     <= ST_AZ;
          end
        end
        ST_AZ: begin
          if (cor_rsp.done) begin
            cor_angle_q <= pose.polar;
            cor_start_q <= 1'b1;
            state_q     <= ST_POL;
          end
        end
        ST_POL: begin
          if (cor_rsp.done) begin
            state_q <= ST_MUL_RC;
          end
        end
        ST_MUL_RC: state_q <= ST_RC;
        ST_RC:     state_q <= ST_MUL_X;
        // Hold here until the output register is free for the new eye position.
        ST_MUL_X: begin
          if (!out_valid_q || m_axis_tready_i) begin
            state_q <= ST_EYE_X;
          end
        end
        ST_EYE_X:  state_q <= ST_MUL_Y;
        ST_MUL_Y:  state_q <= ST_EYE_Y;
        ST_EYE_Y:  state_q <= ST_MUL_Z;
        ST_MUL_Z:  state_q <= ST_EYE_Z;
        ST_EYE_Z: begin
          out_valid_q <= 1'b1;
          state_q     <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers loaded under sequencer control.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_AZ && cor_rsp.done) begin
      ca_q <= neg_q ? -cor_rsp.cos_val : cor_rsp.cos_val;
      sa_q <= neg_q ? -cor_rsp.sin_val : cor_rsp.sin_val;
    end
    if (state_q == ST_POL && cor_rsp.done) begin
      cp_q <= cor_rsp.cos_val;
      sp_q <= cor_rsp.sin_val;
    end
    if (state_q == ST_RC) begin
      rc_q <= CordW'(prod_rnd);
    end
    if (state_q == ST_EYE_X) begin
      ex_q <= eye_sat;
    end
    if (state_q == ST_EYE_Y) begin
      ey_q <= eye_sat;
    end
    if (state_q == ST_EYE_Z) begin
      ez_q <= eye_sat;
    end
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{PadW{1'b0}}, ez_q, ey_q, ex_q};

  // A result waiting for the receiver stays valid and unchanged.
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> (m_axis_tvalid_o && $stable(m_axis_tdata_o)))
    else $error("pending result changed before it was taken");

  // An accepted transaction starts the pose update on the next cycle.
  a_pose_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_txn |=> (pose_req.start && state_q == ST_POSE))
    else $error("pose update not started after input transaction");

  // The CORDIC only finishes while the sequencer waits for it.
  a_cordic_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cor_rsp.done |-> (state_q == ST_AZ || state_q == ST_POL))
    else $error("unexpected CORDIC completion");

endmodule

FILE: rtl/core/ocep_cordic.sv
// Iterative rotation-mode CORDIC that returns cosine and sine of a Q2.12 angle in Q24.
`timescale 1ns / 1ps

module ocep_cordic #(
  parameter int unsigned Steps = 14
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ocep_pkg::ocep_cordic_req_t req_i,
  output ocep_pkg::ocep_cordic_rsp_t rsp_o
);

  localparam int unsigned CordW = ocep_pkg::CordW;
  localparam int unsigned IdxW  = ocep_pkg::AtanIdxW;
  localparam int unsigned IterW = $clog2(Steps);
  localparam int unsigned ZFrac = 12;

  logic                    busy_q;
  logic                    done_q;
  logic [IterW-1:0]        iter_q;
  logic signed [CordW-1:0] x_q, y_q, z_q;

  logic signed [CordW-1:0] dx, dy, atan_v;
  logic                    last_iter;

  // One micro-rotation per cycle through the shared shifter and adders.
  assign dx        = y_q >>> iter_q;
  assign dy        = x_q >>> iter_q;
  assign atan_v    = ocep_pkg::atan_q24(IdxW'(iter_q));
  assign last_iter = (iter_q == IterW'(Steps - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        iter_q <= '0;
      end else if (busy_q) begin
        if (last_iter) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          iter_q <= iter_q + 1'b1;
        end
      end
    end
  end

  // Vector and residual angle; the gain is applied up front.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      x_q <= ocep_pkg::CordicGain;
      y_q <= '0;
      z_q <= CordW'(req_i.angle) <<< ZFrac;
    end else if (busy_q) begin
      if (!z_q[CordW-1]) begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - atan_v;
      end else begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + atan_v;
      end
    end
  end

  assign rsp_o.done    = done_q;
  assign rsp_o.cos_val = x_q;
  assign rsp_o.sin_val = y_q;

endmodule

FILE: rtl/core/ocep_pose.sv
// Pose state unit: holds azimuth, polar angle and radius and applies one operation per request.
`timescale 1ns / 1ps

module ocep_pose (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ocep_pkg::ocep_pose_req_t req_i,
  input  ocep_pkg::ocep_cfg_t      cfg_i,
  output ocep_pkg::ocep_pose_t     pose_o
);

  localparam int unsigned AzW    = ocep_pkg::AzW;
  localparam int unsigned PolW   = ocep_pkg::PolW;
  localparam int unsigned RadW   = ocep_pkg::RadW;
  localparam int unsigned WorkW  = AzW + 3;
  localparam int unsigned PSumW  = ocep_pkg::DeltaW + 1;
  localparam int unsigned RSumW  = RadW + 2;

  typedef enum logic {
    ST_IDLE,
    ST_WRAP
  } state_e;

  state_e                  state_q;
  logic                    done_q;
  logic [AzW-1:0]          az_q;
  logic signed [PolW-1:0]  pol_q;
  logic [RadW-1:0]         rad_q;
  logic signed [WorkW-1:0] work_q;

  logic signed [WorkW-1:0] az_sum, two_pi_w;
  logic signed [PSumW-1:0] pol_sum, start_pol_w, cap_w;
  logic signed [PolW-1:0]  pol_step, pol_start;
  logic signed [RSumW-1:0] rad_sum, min_w, max_w;
  logic [RadW-1:0]         rad_zoom;

  assign two_pi_w = WorkW'(ocep_pkg::TwoPiQ12);
  assign cap_w    = PSumW'(ocep_pkg::PolarCap);

  // Azimuth step before wrapping.
  assign az_sum = $signed({3'b000, az_q}) + WorkW'(req_i.delta);

  // Polar step and restart value, both clamped to the cap.
  assign pol_sum     = PSumW'(pol_q) + PSumW'(req_i.delta);
  assign start_pol_w = PSumW'(cfg_i.start_polar);

  always_comb begin
    if (pol_sum > cap_w) begin
      pol_step = PolW'(cap_w);
    end else if (pol_sum < -cap_w) begin
      pol_step = PolW'(-cap_w);
    end else begin
      pol_step = PolW'(pol_sum);
    end
    if (start_pol_w > cap_w) begin
      pol_start = PolW'(cap_w);
    end else if (start_pol_w < -cap_w) begin
      pol_start = PolW'(-cap_w);
    end else begin
      pol_start = cfg_i.start_polar;
    end
  end

  // Zoom: floor at the minimum radius first, then saturate at the top.
  assign rad_sum = $signed({2'b00, rad_q}) - RSumW'(req_i.delta);
  assign min_w   = $signed({2'b00, cfg_i.min_radius});
  assign max_w   = $signed({2'b00, ocep_pkg::RadiusMax});

  always_comb begin
    if (rad_sum < min_w) begin
      rad_zoom = cfg_i.min_radius;
    end else if (rad_sum > max_w) begin
      rad_zoom = ocep_pkg::RadiusMax;
    end else begin
      rad_zoom = RadW'(rad_sum);
    end
  end

  // Update, then bring the azimuth into [0, 2pi) one turn per cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
      az_q    <= '0;
      pol_q   <= '0;
      rad_q   <= 23'd2560;
      work_q  <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (req_i.start) begin
            state_q <= ST_WRAP;
            case (req_i.opcode)
              ocep_pkg::OP_ROT_AZ: begin
                work_q <= az_sum;
              end
              ocep_pkg::OP_ROT_POL: begin
                work_q <= $signed({3'b000, az_q});
                pol_q  <= pol_step;
              end
              ocep_pkg::OP_ZOOM: begin
                work_q <= $signed({3'b000, az_q});
                rad_q  <= rad_zoom;
              end
              ocep_pkg::OP_RESTART: begin
                work_q <= $signed({3'b000, cfg_i.start_azimuth});
                pol_q  <= pol_start;
                rad_q  <= cfg_i.start_radius;
              end
              default: begin
                work_q <= $signed({3'b000, az_q});
              end
            endcase
          end
        end
        ST_WRAP: begin
          if (work_q[WorkW-1]) begin
            work_q <= work_q + two_pi_w;
          end else if (work_q >= two_pi_w) begin
            work_q <= work_q - two_pi_w;
          end else begin
            az_q    <= AzW'(work_q);
            done_q  <= 1'b1;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign pose_o.done    = done_q;
  assign pose_o.azimuth = az_q;
  assign pose_o.polar   = pol_q;
  assign pose_o.radius  = rad_q;

  // The stored azimuth never leaves [0, 2pi).
  a_az_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $signed({1'b0, az_q}) < ocep_pkg::TwoPiQ12)
    else $error("azimuth out of range");

  // The stored polar angle stays within the cap.
  a_pol_cap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (PSumW'(pol_q) <= cap_w) && (PSumW'(pol_q) >= -cap_w))
    else $error("polar angle beyond cap");

  // Completion is a single-cycle strobe.
  a_done_pulse : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("pose done held longer than one cycle");

endmodule
